// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/bgad_pkg.sv =====
// ---------------------------------------------------------------------------
// bgad_pkg
// Shared types and constants of the bilevel to gray box downscaler.
// ---------------------------------------------------------------------------
package bgad_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_FACTOR = 8;
    localparam int COL_AW     = $clog2(MAX_WIDTH);
    localparam int COUNT_W    = 7;

    localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_LOW_STEP   = 3'd4;
    localparam logic [2:0] REG_BIT_ORDER  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAND,
        ST_ROW,
        ST_SPAN,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_POST,
        ST_EMIT,
        ST_ADV,
        ST_FIN,
        ST_EMITL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_band;
        logic start_row;
        logic next_span;
        logic rd;
        logic acc;
        logic div_step;
        logic capture;
        logic pend_clear;
        logic adv;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic bit_col_zero;
        logic band_row_zero;
        logic band_ok;
        logic ow_nonzero;
        logic loop_go;
        logic span_ended;
        logic emit_now;
        logic div_last;
        logic pend_valid;
        logic more_spans;
    } t_stat;

endpackage

// ===== hdl/bgad_ram.sv =====
// ---------------------------------------------------------------------------
// bgad_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bgad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/bgad_ctrl.sv =====
// ---------------------------------------------------------------------------
// bgad_ctrl
// Sequencer: walks one input byte through band, row, span and emit steps.
// ---------------------------------------------------------------------------
module bgad_ctrl import bgad_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_stall,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_BAND;
            end
            ST_BAND: begin
                if (!i_stat.bit_col_zero)                     n_state = ST_RD;
                else if (!i_stat.band_row_zero)               n_state = ST_ROW;
                else if (i_stat.band_ok)                      n_state = ST_ROW;
                else                                          n_state = ST_IDLE;
            end
            ST_ROW:  n_state = i_stat.ow_nonzero ? ST_SPAN : ST_RD;
            ST_SPAN: n_state = ST_RD;
            ST_RD:   n_state = i_stat.loop_go ? ST_ACC : ST_FIN;
            ST_ACC: begin
                if (!i_stat.span_ended)   n_state = ST_FIN;
                else if (i_stat.emit_now) n_state = ST_DIV;
                else                      n_state = ST_ADV;
            end
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_POST;
            end
            ST_POST: n_state = i_stat.pend_valid ? ST_EMIT : ST_ADV;
            ST_EMIT: begin
                if (!i_out_stall) n_state = ST_ADV;
            end
            ST_ADV:  n_state = i_stat.more_spans ? ST_SPAN : ST_RD;
            ST_FIN:  n_state = i_stat.pend_valid ? ST_EMITL : ST_DONE;
            ST_EMITL: begin
                if (!i_out_stall) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:  o_cmd.accept     = i_in_valid;
            ST_BAND:  o_cmd.start_band = i_stat.bit_col_zero && i_stat.band_row_zero
                                         && i_stat.band_ok;
            ST_ROW:   o_cmd.start_row  = 1'b1;
            ST_SPAN:  o_cmd.next_span  = 1'b1;
            ST_RD:    o_cmd.rd         = i_stat.loop_go;
            ST_ACC:   o_cmd.acc        = 1'b1;
            ST_DIV:   o_cmd.div_step   = 1'b1;
            ST_POST:  o_cmd.capture    = !i_stat.pend_valid;
            ST_EMIT:  o_cmd.capture    = !i_out_stall;
            ST_ADV:   o_cmd.adv        = 1'b1;
            ST_FIN:   o_cmd            = '0;
            ST_EMITL: o_cmd.pend_clear = !i_out_stall;
            ST_DONE:  o_cmd.done       = 1'b1;
            default:  o_cmd            = '0;
        endcase
    end

endmodule

// ===== hdl/bgad_dp.sv =====
// ---------------------------------------------------------------------------
// bgad_dp
// Datapath: registers, position counters, error terms, span popcount,
// column counter RAM, 4-step gray divider and the pending result.
// ---------------------------------------------------------------------------
module bgad_dp import bgad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [7:0]  i_pixel_byte,
    input  logic        i_frame_start,
    output logic [3:0]  o_gray,
    output logic [11:0] o_out_col,
    output logic [15:0] o_out_row,
    output logic        o_row_end
);

    // configuration
    logic [12:0] r_in_w;
    logic [15:0] r_in_h;
    logic [12:0] r_out_w;
    logic [15:0] r_out_h;
    logic [3:0]  r_low_step;
    logic        r_bit_order;

    // position state
    logic [7:0]        r_byte;
    logic [13:0]       r_bit_col;
    logic [15:0]       r_in_row;
    logic [15:0]       r_out_row;
    logic [39:0]       r_row_err;
    logic [3:0]        r_band_step;
    logic [3:0]        r_band_row;
    logic [31:0]       r_col_err;
    logic [COL_AW:0]   r_span_col;
    logic [3:0]        r_span_step;
    logic [13:0]       r_span_end;
    logic [3:0]        r_closed;

    // divider and pending result
    logic [COUNT_W-1:0] r_rem;
    logic [6:0]         r_area;
    logic               r_sat;
    logic               r_zero;
    logic [3:0]         r_quot;
    logic [1:0]         r_div_cnt;
    logic               r_pend_valid;
    logic [3:0]         r_pend_gray;
    logic [11:0]        r_pend_col;
    logic [15:0]        r_pend_row;
    logic               r_pend_end;

    logic [12:0] w_ow;
    logic [10:0] w_row_bytes;
    logic [13:0] w_row_end_pos;
    logic [13:0] w_p8;
    logic        w_last_byte;

    assign w_ow          = (r_out_w > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_out_w;
    assign w_row_bytes   = (r_in_w == 13'd0) ? 11'd1 : 11'((14'(r_in_w) + 14'd7) >> 3);
    assign w_row_end_pos = {w_row_bytes, 3'b000};
    assign w_p8          = r_bit_col + 14'd8;
    assign w_last_byte   = w_p8 >= w_row_end_pos;

    // band step
    logic [19:0] w_ls_oh;
    logic [39:0] w_re_sum;
    logic [39:0] w_re_new;
    logic [4:0]  w_bstep_raw;
    logic [4:0]  w_bstep_cl;
    logic [16:0] w_row_reach;
    logic [3:0]  w_bstep;

    assign w_ls_oh  = 20'(r_low_step) * 20'(r_out_h);
    assign w_re_sum = r_row_err + 40'(w_ls_oh) - 40'(r_in_h);

    always_comb begin
        w_re_new    = w_re_sum;
        w_bstep_raw = 5'(r_low_step);
        if (w_re_sum[39]) begin
            w_re_new    = w_re_sum + 40'(r_out_h);
            w_bstep_raw = 5'(r_low_step) + 5'd1;
        end
        w_bstep_cl = (w_bstep_raw > 5'(MAX_FACTOR)) ? 5'(MAX_FACTOR) : w_bstep_raw;
        if (w_bstep_cl == 5'd0) w_bstep_cl = 5'd1;
        w_row_reach = 17'(r_in_row) + 17'(w_bstep_cl);
        if (w_row_reach > 17'(r_in_h)) begin
            w_bstep = 4'(r_in_h - r_in_row);
        end else begin
            w_bstep = 4'(w_bstep_cl);
        end
    end

    // span step
    logic [16:0] w_ls_ow;
    logic [31:0] w_ce_sum;
    logic [31:0] w_ce_new;
    logic [4:0]  w_sstep_raw;
    logic [3:0]  w_sstep;
    logic [13:0] w_end;

    assign w_ls_ow  = 17'(r_low_step) * 17'(w_ow);
    assign w_ce_sum = r_col_err + 32'(w_ls_ow) - 32'(r_in_w);

    always_comb begin
        w_ce_new    = w_ce_sum;
        w_sstep_raw = 5'(r_low_step);
        if (w_ce_sum[31]) begin
            w_ce_new    = w_ce_sum + 32'(w_ow);
            w_sstep_raw = 5'(r_low_step) + 5'd1;
        end
        w_sstep = (w_sstep_raw > 5'(MAX_FACTOR)) ? 4'(MAX_FACTOR) : 4'(w_sstep_raw);
        w_end   = r_span_end + 14'(w_sstep);
        if (w_end > 14'(r_in_w)) w_end = 14'(r_in_w);
        if (w_end < r_span_end)  w_end = r_span_end;
    end

    // pixels of the current span inside this byte
    logic [13:0]        w_span_start;
    logic [13:0]        w_lo;
    logic [13:0]        w_hi;
    logic [3:0]         w_cnt;
    logic [COUNT_W-1:0] w_rdata;
    logic [COUNT_W-1:0] w_new_count;
    logic               w_ended;
    logic [6:0]         w_area;

    assign w_span_start = r_span_end - 14'(r_span_step);
    assign w_lo = (w_span_start > r_bit_col) ? w_span_start : r_bit_col;
    assign w_hi = (r_span_end < w_p8) ? r_span_end : w_p8;

    always_comb begin
        logic [13:0] pos;
        logic        pix;
        w_cnt = 4'd0;
        for (int k = 0; k < 8; k++) begin
            pos = r_bit_col + 14'(k);
            pix = r_bit_order ? r_byte[k] : r_byte[7-k];
            if (pos >= w_lo && pos < w_hi && pix) w_cnt = w_cnt + 4'd1;
        end
    end

    assign w_new_count = w_rdata + COUNT_W'(w_cnt);
    assign w_ended     = (r_span_end <= w_p8) || w_last_byte;
    assign w_area      = 7'(r_span_step) * 7'(r_band_step);

    // divider step
    logic [COUNT_W:0] w_rem2;
    assign w_rem2 = {r_rem, 1'b0};

    // column counter store
    logic                w_we;
    logic [COUNT_W-1:0]  w_wdata;

    assign w_we    = (i_cmd.next_span && r_band_row == 4'd0) || i_cmd.acc;
    assign w_wdata = i_cmd.acc ? w_new_count : '0;

    bgad_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_span_col[COL_AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_span_col[COL_AW-1:0]),
        .o_rdata (w_rdata)
    );

    logic [3:0] w_gray;
    assign w_gray = r_zero ? 4'd0 : (r_sat ? 4'd15 : r_quot);

    logic [13:0] w_bit_col_n;
    logic [3:0]  w_band_row_n;
    assign w_bit_col_n  = w_p8;
    assign w_band_row_n = r_band_row + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_w       <= 13'd1;
            r_in_h       <= 16'd1;
            r_out_w      <= 13'd1;
            r_out_h      <= 16'd1;
            r_low_step   <= 4'd1;
            r_bit_order  <= 1'b0;
            r_bit_col    <= '0;
            r_in_row     <= '0;
            r_out_row    <= '0;
            r_row_err    <= '0;
            r_band_step  <= '0;
            r_band_row   <= '0;
            r_col_err    <= '0;
            r_span_col   <= '0;
            r_span_step  <= '0;
            r_span_end   <= '0;
            r_closed     <= '0;
            r_div_cnt    <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IN_WIDTH:   r_in_w      <= i_cfg_data[12:0];
                    REG_IN_HEIGHT:  r_in_h      <= i_cfg_data;
                    REG_OUT_WIDTH:  r_out_w     <= i_cfg_data[12:0];
                    REG_OUT_HEIGHT: r_out_h     <= i_cfg_data;
                    REG_LOW_STEP:   r_low_step  <= i_cfg_data[3:0];
                    REG_BIT_ORDER:  r_bit_order <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_closed <= '0;
                if (i_frame_start) begin
                    r_bit_col   <= '0;
                    r_in_row    <= '0;
                    r_out_row   <= '0;
                    r_row_err   <= 40'(r_out_h >> 1);
                    r_band_step <= '0;
                    r_band_row  <= '0;
                    r_col_err   <= 32'(w_ow >> 1);
                    r_span_col  <= '0;
                    r_span_step <= '0;
                    r_span_end  <= '0;
                end
            end
            if (i_cmd.start_band) begin
                r_row_err   <= w_re_new;
                r_band_step <= w_bstep;
            end
            if (i_cmd.start_row) begin
                r_col_err  <= 32'(w_ow >> 1);
                r_span_col <= '0;
                r_span_end <= '0;
            end
            if (i_cmd.next_span) begin
                r_col_err   <= w_ce_new;
                r_span_step <= 4'(w_end - r_span_end);
                r_span_end  <= w_end;
            end
            if (i_cmd.acc) begin
                if (w_ended) r_closed <= r_closed + 4'd1;
                r_div_cnt <= '0;
            end
            if (i_cmd.div_step) r_div_cnt <= r_div_cnt + 2'd1;
            if (i_cmd.capture)  r_pend_valid <= 1'b1;
            if (i_cmd.pend_clear) r_pend_valid <= 1'b0;
            if (i_cmd.adv) r_span_col <= r_span_col + 1'b1;
            if (i_cmd.done) begin
                if (w_bit_col_n >= w_row_end_pos) begin
                    r_bit_col <= '0;
                    r_in_row  <= r_in_row + 16'd1;
                    if (w_band_row_n >= r_band_step) begin
                        r_band_row <= '0;
                        r_out_row  <= r_out_row + 16'd1;
                    end else begin
                        r_band_row <= w_band_row_n;
                    end
                end else begin
                    r_bit_col <= w_bit_col_n;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_byte <= i_pixel_byte;
        if (i_cmd.acc) begin
            r_rem  <= w_new_count;
            r_area <= w_area;
            r_zero <= (w_area == 7'd0);
            r_sat  <= (w_new_count >= w_area);
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_rem2 >= 8'(r_area)) begin
                r_rem  <= COUNT_W'(w_rem2 - 8'(r_area));
                r_quot <= {r_quot[2:0], 1'b1};
            end else begin
                r_rem  <= COUNT_W'(w_rem2);
                r_quot <= {r_quot[2:0], 1'b0};
            end
        end
        if (i_cmd.capture) begin
            r_pend_gray <= w_gray;
            r_pend_col  <= r_span_col[11:0];
            r_pend_row  <= r_out_row;
            r_pend_end  <= (r_span_col + 1'b1) == (COL_AW+1)'(w_ow);
        end
    end

    assign o_gray    = r_pend_gray;
    assign o_out_col = r_pend_col;
    assign o_out_row = r_pend_row;
    assign o_row_end = r_pend_end;

    assign o_stat.bit_col_zero  = (r_bit_col == 14'd0);
    assign o_stat.band_row_zero = (r_band_row == 4'd0);
    assign o_stat.band_ok       = (r_out_row < r_out_h) && (r_in_row < r_in_h);
    assign o_stat.ow_nonzero    = (w_ow != 13'd0);
    assign o_stat.loop_go       = ((COL_AW+1)'(r_span_col) < (COL_AW+1)'(w_ow))
                                  && (r_closed < 4'd8);
    assign o_stat.span_ended    = w_ended;
    assign o_stat.emit_now      = (w_band_row_n >= r_band_step);
    assign o_stat.div_last      = (r_div_cnt == 2'd3);
    assign o_stat.pend_valid    = r_pend_valid;
    assign o_stat.more_spans    = ((r_span_col + 1'b1) < (COL_AW+1)'(w_ow));

endmodule

// ===== hdl/bitmap_to_gray_area_downscale_top.sv =====
// ---------------------------------------------------------------------------
// bitmap_to_gray_area_downscale_top
// Bilevel bitmap to 4-bit gray box downscaler, top level.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_stall       i_pixel_byte, i_frame_start
// output    out        o_out_valid / i_out_stall     o_gray, o_out_col, o_out_row,
//                                                    o_row_end, o_last
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item at a time. An item runs through the band step, at a row start
// also the row and first span set-up, then for each column spanned by the
// byte a RAM read, accumulate, advance and next span, plus the 4-step gray
// divider and emit where a column closes on the last row of its band; an
// ignored byte goes back to idle from the band step. The column counter
// RAM port and the serial divider set the pace. Results are held back by
// one so the final one can carry o_last; an output stall simply holds the
// sequencer. Reset is synchronous and clears control state only; no
// clearing pass is run over the counter RAM.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_to_gray_area_downscale_top import bgad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pixel_byte,
    input  logic        i_frame_start,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_gray,
    output logic [11:0] o_out_col,
    output logic [15:0] o_out_row,
    output logic        o_row_end,
    output logic        o_last,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    bgad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    bgad_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_start (i_frame_start),
        .o_gray        (o_gray),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_row_end     (o_row_end)
    );

    // only idle takes a new item or a register write
    assign o_in_stall  = (w_state != ST_IDLE);
    assign o_cfg_ready = (w_state == ST_IDLE);

    // the pending result goes out ahead of a newer one, or as the last one
    assign o_out_valid = (w_state == ST_EMIT) || (w_state == ST_EMITL);
    assign o_last      = (w_state == ST_EMITL);

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `ASSERT_NEVER(a_out_when_idle, i_clk, i_rst_n, o_out_valid && !o_in_stall)
    `ASSERT_CLK(a_out_has_pend, i_clk, i_rst_n, o_out_valid |-> w_stat.pend_valid)

endmodule

// ===== bench/bgad_checker.sv =====
// ---------------------------------------------------------------------------
// bgad_checker
// Watches the byte, result and register channels of the gray downscaler.
// Keeps its own copy of the registers and the scan state, works out the gray
// pixels that each accepted byte should close, and compares every accepted
// result with the oldest outstanding one.
// ---------------------------------------------------------------------------
module bgad_checker import bgad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_pixel_byte,
    input  logic        i_frame_start,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_gray,
    input  logic [11:0] i_out_col,
    input  logic [15:0] i_out_row,
    input  logic        i_row_end,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  gray;
        logic [11:0] col;
        logic [15:0] row;
        logic        row_end;
        logic        last;
    } t_pix;

    t_pix gray_due[$];

    // register copy
    int unsigned in_w, in_h, out_w, out_h, low_stp, lsb_first;
    // scan state
    logic [6:0]  col_sum [MAX_WIDTH];
    int unsigned in_row, bit_col, out_row, band_stp, band_row;
    int unsigned span_col, span_len, span_end;
    longint      row_err, col_err;

    assign o_pending = gray_due.size();

    function automatic int unsigned cols_used();
        return out_w > MAX_WIDTH ? MAX_WIDTH : out_w;
    endfunction

    task automatic restart_image();
        in_row = 0; bit_col = 0; out_row = 0;
        row_err = longint'(out_h / 2);
        band_stp = 0; band_row = 0;
        col_err = longint'(cols_used() / 2);
        span_col = 0; span_len = 0; span_end = 0;
    endtask

    task automatic open_span();
        int unsigned ow, stp, s, e;
        ow  = cols_used();
        stp = low_stp;
        col_err += longint'(low_stp) * longint'(ow) - longint'(in_w);
        if (col_err < 0) begin
            col_err += longint'(ow);
            stp++;
        end
        if (stp > MAX_FACTOR) stp = MAX_FACTOR;
        s = span_end;
        e = s + stp;
        if (e > in_w) e = in_w;
        if (e < s) e = s;
        span_len = e - s;
        span_end = e;
        if (band_row == 0 && span_col < MAX_WIDTH) col_sum[span_col] = '0;
    endtask

    task automatic open_band(output bit ok);
        int unsigned stp;
        stp = low_stp;
        ok  = 0;
        if (out_row >= out_h || in_row >= in_h) return;
        row_err += longint'(low_stp) * longint'(out_h) - longint'(in_h);
        if (row_err < 0) begin
            row_err += longint'(out_h);
            stp++;
        end
        if (stp > MAX_FACTOR) stp = MAX_FACTOR;
        if (stp == 0) stp = 1;
        if (in_row + stp > in_h) stp = in_h - in_row;
        band_stp = stp;
        ok = 1;
    endtask

    // gray pixels closed by one byte
    task automatic shade_byte(input logic [7:0] pix, input logic fs);
        t_pix        batch[$];
        t_pix        px;
        bit          ok;
        int unsigned ow, p, row_end_pos, rb, closed, s, e, lo, hi, cnt, k, area, g;
        bit          last_byte;
        closed = 0;
        if (fs) restart_image();
        if (bit_col == 0) begin
            if (band_row == 0) begin
                open_band(ok);
                if (!ok) return;
            end
            col_err  = longint'(cols_used() / 2);
            span_col = 0;
            span_end = 0;
            if (cols_used() > 0) open_span();
        end
        ow = cols_used();
        p  = bit_col;
        rb = (in_w + 7) / 8;
        if (rb == 0) rb = 1;
        row_end_pos = rb * 8;
        last_byte = (p + 8 >= row_end_pos);
        while (span_col < ow && closed < 8) begin
            e  = span_end;
            s  = span_end - span_len;
            lo = s > p ? s : p;
            hi = e < p + 8 ? e : p + 8;
            cnt = 0;
            for (int unsigned i = lo; i < hi; i++) begin
                k = i - p;
                cnt += pix[lsb_first ? k : 7 - k];
            end
            col_sum[span_col] = col_sum[span_col] + cnt[6:0];
            if (!(e <= p + 8 || last_byte)) break;
            closed++;
            if (band_row + 1 >= band_stp) begin
                area = span_len * band_stp;
                g = 0;
                if (area != 0) begin
                    g = (int'(col_sum[span_col]) * 16) / area;
                    if (g > 15) g = 15;
                end
                px.gray    = g[3:0];
                px.col     = span_col[11:0];
                px.row     = out_row[15:0];
                px.row_end = (span_col + 1 == ow);
                px.last    = 1'b0;
                batch.push_back(px);
            end
            span_col++;
            if (span_col < ow) open_span();
        end
        if (batch.size() > 0) batch[$].last = 1'b1;
        foreach (batch[j]) gray_due.push_back(batch[j]);
        bit_col += 8;
        if (bit_col >= row_end_pos) begin
            bit_col = 0;
            in_row = (in_row + 1) & 32'hFFFF;
            band_row++;
            if (band_row >= band_stp) begin
                band_row = 0;
                out_row = (out_row + 1) & 32'hFFFF;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pix want;
        if (!i_rst_n) begin
            in_w = 1; in_h = 1; out_w = 1; out_h = 1; low_stp = 1; lsb_first = 0;
            foreach (col_sum[i]) col_sum[i] = '0;
            restart_image();
            gray_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IN_WIDTH:   in_w      = i_cfg_data & 16'h1FFF;
                    REG_IN_HEIGHT:  in_h      = i_cfg_data;
                    REG_OUT_WIDTH:  out_w     = i_cfg_data & 16'h1FFF;
                    REG_OUT_HEIGHT: out_h     = i_cfg_data;
                    REG_LOW_STEP:   low_stp   = i_cfg_data & 16'hF;
                    REG_BIT_ORDER:  lsb_first = i_cfg_data & 16'h1;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) shade_byte(i_pixel_byte, i_frame_start);
            if (i_out_valid && !i_out_stall) begin
                if (gray_due.size() == 0) begin
                    $display("%0t: unexpected result gray=%0d col=%0d row=%0d",
                             $time, i_gray, i_out_col, i_out_row);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = gray_due.pop_front();
                    if (want !== {i_gray, i_out_col, i_out_row, i_row_end, i_last}) begin
                        $display("%0t: mismatch exp gray=%0d col=%0d row=%0d re=%0b last=%0b",
                                 $time, want.gray, want.col, want.row, want.row_end,
                                 want.last);
                        $display("%0t:          got gray=%0d col=%0d row=%0d re=%0b last=%0b",
                                 $time, i_gray, i_out_col, i_out_row, i_row_end, i_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bilevel to gray box downscaler.
// Directed images cover the register extremes and corner cases, then random
// images of small size with random idle gaps and output stalls. The checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb import bgad_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;  // cycles with no item moving
    localparam int SETTLE      = 150;   // worst-case work on an item with no result

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_pixel_byte = '0;
    logic        i_frame_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_gray;
    logic [11:0] o_out_col;
    logic [15:0] o_out_row;
    logic        o_row_end;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int quiet;
    bit calm;        // no gaps and no stalls while set
    int byte_total;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bitmap_to_gray_area_downscale_top DUT (.*);

    bgad_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_pixel_byte,
        .i_frame_start, .i_out_valid(o_out_valid), .i_out_stall, .i_gray(o_gray),
        .i_out_col(o_out_col), .i_out_row(o_out_row), .i_row_end(o_row_end),
        .i_last(o_last), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog: any handshake clears the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        int n;
        forever begin
            n = gap_len();
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // one item on the byte channel; valid stays high into the next item
    // unless a gap is drawn
    task automatic send_byte(input logic [7:0] pix, input logic fs);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_pixel_byte  = pix;
        i_frame_start = fs;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        byte_total++;
    endtask

    // block must be idle before any register write
    task automatic drain();
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic setup(input int unsigned iw, ih, ow, oh, ls, bo);
        drain();
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_IN_HEIGHT, ih);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_LOW_STEP, ls);
        write_reg(REG_BIT_ORDER, bo);
    endtask

    function automatic logic [7:0] rand_pix();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // one image with random content, sometimes cut short, padded or restarted
    task automatic random_image(input int unsigned iw, ih);
        int unsigned rb, total;
        rb = (iw + 7) / 8;
        if (rb == 0) rb = 1;
        total = rb * ih;
        case ($urandom_range(0, 9))
            0: total = $urandom_range(1, total);
            1: total = total + $urandom_range(1, 6);   // tail bytes are ignored
            default: ;
        endcase
        for (int unsigned i = 0; i < total; i++)
            send_byte(rand_pix(), i == 0 || $urandom_range(0, 59) == 0);
    endtask

    initial begin
        int unsigned iw, ih, ow, oh, ls;
        byte_total = 0;
        calm = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers: one pixel image
        send_byte(8'h80, 1'b0);

        // 2:1 with the leftmost pixel in bit 7, then 16 to 5 columns with it in bit 0
        setup(16, 4, 8, 2, 2, 0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hFF, 1'b0);   // image finished, ignored
        setup(16, 2, 5, 1, 3, 1);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        // zero row step
        setup(8, 2, 3, 2, 0, 0);
        send_byte(8'hE7, 1'b1);
        send_byte(8'h3C, 1'b0);
        // step above the maximum factor, band clamped at the bottom edge
        setup(20, 1, 1, 1, 15, 1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        // zero width
        setup(0, 2, 3, 1, 2, 0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        // crowded byte: more output columns than pixels
        setup(8, 1, 8191, 1, 1, 0);
        send_byte(8'hA5, 1'b1);
        // no output rows at all
        setup(8, 3, 1, 0, 2, 1);
        send_byte(8'hFF, 1'b1);

        // widest and tallest: the opening bytes of a 4096 column row
        setup(4096, 65535, 4096, 65535, 1, $urandom_range(0, 1));
        for (int i = 0; i < 48; i++) send_byte(8'($urandom), i == 0);

        while (byte_total < 320) begin
            drain();
            calm = ($urandom_range(0, 3) == 0);
            ls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            iw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
            ih = $urandom_range(1, 10);
            ow = (iw + ls / 2) / (ls == 0 ? 1 : ls);
            ow = ow + $urandom_range(0, 2);
            if (ow > 1) ow = ow - 1;
            oh = (ih + ls / 2) / (ls == 0 ? 1 : ls);
            oh = oh + $urandom_range(0, 2);
            if (oh > 1) oh = oh - 1;
            setup(iw, ih, ow, oh, ls, $urandom_range(0, 1));
            repeat ($urandom_range(1, 2)) random_image(iw, ih);
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
